/* rtl/lfu_pkg.sv */
// Shared constants and control/status types for the LFU cache lookup.
`default_nettype none
package lfu_pkg;

  localparam int LINES       = 16;
  localparam int OFFSET_BITS = 4;
  localparam int ADDR_BITS   = 48;
  localparam int COUNT_BITS  = 16;
  localparam int TOTAL_BITS  = 32;
  localparam int CFG_BITS    = 5;
  localparam int IDX_BITS    = 4;
  localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS;

  localparam int IN_DATA_BITS  = ((ADDR_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = 2 + IDX_BITS + 3 * TOTAL_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic [CFG_BITS-1:0] LINES_RESET = CFG_BITS'(LINES);

  typedef struct packed {
    logic start;   // capture address, clear scan state
    logic step;    // examine one line
    logic commit;  // update line, totals and result word
  } lfu_cmd_t;

  typedef struct packed {
    logic match;   // line under scan is valid and holds the tag
    logic last;    // line under scan is the last active one
  } lfu_sts_t;

endpackage
`default_nettype wire

/* rtl/lfu_associative_cache_lookup.sv */
// Top level of the LFU fully associative cache lookup.
//
//  Channel   Ports                              Contents (low bit up)
//  in        in_tvalid/in_tready/in_tdata       address[47:0]
//  out       out_tvalid/out_tready/out_tdata    hit, evicted, line_used[3:0],
//                                               hit_total, miss_total,
//                                               eviction_total, 2 pad bits
//  cfg       cfg_wen/cfg_wdata                  active_lines[4:0]
//
//  Each word passes through accept, a scan of 1 to N lines (N = active lines;
//  the scan stops at the first matching line) and then commit.
//  The scan reads one line per cycle from the line store.
//  Reset clears all lines to invalid, the totals to zero and active_lines to 16.
//  A result waiting on out_tready holds the next commit; a new address is
//  taken while the previous result waits.
`default_nettype none
module lfu_associative_cache_lookup (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [lfu_pkg::IN_DATA_BITS-1:0]    in_tdata,   // address
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // hit, evicted, line_used, hit_total, miss_total, eviction_total
  output logic [lfu_pkg::OUT_DATA_BITS-1:0]        out_tdata,
  input  wire logic                                cfg_wen,
  input  wire logic [lfu_pkg::CFG_BITS-1:0]        cfg_wdata   // active_lines
);
  import lfu_pkg::*;

  lfu_cmd_t cmd;
  lfu_sts_t sts;

  lfu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lfu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .address   (in_tdata[ADDR_BITS-1:0]),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_tdata)
  );

endmodule
`default_nettype wire

/* rtl/lfu_ctrl.sv */
// Controller: sequences accept, line scan and commit, and owns the result handshake.
`default_nettype none
module lfu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire lfu_pkg::lfu_sts_t sts,
  output lfu_pkg::lfu_cmd_t      cmd
);
  import lfu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = out_valid_r;
    cmd.start  = in_tready && in_tvalid;
    cmd.step   = (state_r == ST_SCAN);
    // hold the commit while the previous word is still waiting
    cmd.commit = (state_r == ST_COMMIT) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.match || sts.last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (cmd.commit) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/lfu_dp.sv */
// Datapath: line store, scan for match/empty/victim, totals and result register.
`default_nettype none
module lfu_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [lfu_pkg::ADDR_BITS-1:0]      address,
  input  wire logic                               cfg_wen,
  input  wire logic [lfu_pkg::CFG_BITS-1:0]       cfg_wdata,
  input  wire lfu_pkg::lfu_cmd_t                  cmd,
  output lfu_pkg::lfu_sts_t                       sts,
  output logic [lfu_pkg::OUT_DATA_BITS-1:0]       out_word
);
  import lfu_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  logic [CFG_BITS-1:0]   active_lines_r;
  logic [LINES-1:0]      line_valid_r;
  logic [TAG_BITS-1:0]   line_tag_r   [LINES];
  logic [COUNT_BITS-1:0] line_count_r [LINES];

  logic [TAG_BITS-1:0]   tag_r;
  logic [IDX_BITS-1:0]   idx_r;
  logic                  hit_r;
  logic [IDX_BITS-1:0]   hit_idx_r;
  logic                  have_empty_r;
  logic [IDX_BITS-1:0]   empty_idx_r;
  logic                  have_victim_r;
  logic [IDX_BITS-1:0]   victim_idx_r;
  logic [COUNT_BITS-1:0] victim_count_r;

  logic [TOTAL_BITS-1:0] hits_r, misses_r, evictions_r;

  logic                  res_hit_r, res_evicted_r;
  logic [IDX_BITS-1:0]   res_line_r;

  logic [CFG_BITS-1:0]   lines_lim;
  logic                  cur_valid;
  logic [COUNT_BITS-1:0] cur_count;
  logic [IDX_BITS-1:0]   used_idx;
  logic                  evict;

  // clamp the active line count to 1..LINES
  always_comb begin
    priority if (active_lines_r == '0) begin
      lines_lim = CFG_BITS'(1);
    end else if (active_lines_r > CFG_BITS'(LINES)) begin
      lines_lim = CFG_BITS'(LINES);
    end else begin
      lines_lim = active_lines_r;
    end
  end

  always_comb begin
    cur_valid = line_valid_r[idx_r];
    cur_count = line_count_r[idx_r];
    sts.match = cur_valid && (line_tag_r[idx_r] == tag_r);
    sts.last  = ({1'b0, idx_r} == (lines_lim - CFG_BITS'(1)));
    evict     = !hit_r && !have_empty_r;
    priority if (hit_r) begin
      used_idx = hit_idx_r;
    end else if (have_empty_r) begin
      used_idx = empty_idx_r;
    end else begin
      used_idx = victim_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_lines_r <= LINES_RESET;
    end else if (cfg_wen) begin
      active_lines_r <= cfg_wdata;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r         <= '0;
      hit_r         <= 1'b0;
      have_empty_r  <= 1'b0;
      have_victim_r <= 1'b0;
    end else if (cmd.start) begin
      idx_r         <= '0;
      hit_r         <= 1'b0;
      have_empty_r  <= 1'b0;
      have_victim_r <= 1'b0;
    end else if (cmd.step) begin
      idx_r <= idx_r + IDX_BITS'(1);
      if (cur_valid) begin
        if (sts.match) begin
          hit_r <= 1'b1;
        end else if (!have_victim_r || (cur_count < victim_count_r)) begin
          have_victim_r <= 1'b1;
        end
      end else begin
        have_empty_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tag_r <= address[ADDR_BITS-1:OFFSET_BITS];
    end
    if (cmd.step) begin
      if (cur_valid) begin
        if (sts.match) begin
          hit_idx_r <= idx_r;
        end else if (!have_victim_r || (cur_count < victim_count_r)) begin
          victim_idx_r   <= idx_r;
          victim_count_r <= cur_count;
        end
      end else begin
        empty_idx_r <= idx_r;
      end
    end
  end

  // line store and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_valid_r <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
      evictions_r  <= '0;
    end else if (cmd.commit) begin
      if (hit_r) begin
        if (hits_r != TOTAL_MAX) begin
          hits_r <= hits_r + TOTAL_BITS'(1);
        end
      end else begin
        line_valid_r[used_idx] <= 1'b1;
        if (misses_r != TOTAL_MAX) begin
          misses_r <= misses_r + TOTAL_BITS'(1);
        end
        if (evict && (evictions_r != TOTAL_MAX)) begin
          evictions_r <= evictions_r + TOTAL_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit_r) begin
        if (line_count_r[used_idx] != COUNT_MAX) begin
          line_count_r[used_idx] <= line_count_r[used_idx] + COUNT_BITS'(1);
        end
      end else begin
        line_tag_r[used_idx]   <= tag_r;
        line_count_r[used_idx] <= COUNT_BITS'(1);
      end
      res_hit_r     <= hit_r;
      res_evicted_r <= evict;
      res_line_r    <= used_idx;
    end
  end

  // totals are read after the commit edge, so they already include this word
  assign out_word = OUT_DATA_BITS'({evictions_r, misses_r, hits_r,
                                    res_line_r, res_evicted_r, res_hit_r});

endmodule
`default_nettype wire
